FILE: sv/ugnq_pkg.sv
package ugnq_pkg;

    localparam int MAX_BRICK_ROWS = 16;
    localparam int MAX_BRICK_COLS = 16;
    localparam int MAX_GRID_DIM   = 16;

    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int CNT_W   = 5;
    localparam int CELL_W  = 4;
    localparam int SPAN_W  = 11;
    localparam int SIZE_W  = 10;
    localparam int POS_W   = 16;
    localparam int NUM_W   = 20;
    localparam int DEN_W   = 15;
    localparam int BOUND_W = 17;
    localparam int STEP_W  = 15;
    localparam int ACC_W   = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;
    localparam int DIV_STEPS  = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BOUND,
        ST_COLS,
        ST_ROWS,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH       = 4'd0,
        CFG_SCREEN_HEIGHT      = 4'd1,
        CFG_BRICK_WIDTH        = 4'd2,
        CFG_BRICK_HEIGHT       = 4'd3,
        CFG_GRID_COLUMNS       = 4'd4,
        CFG_GRID_ROWS          = 4'd5,
        CFG_BRICK_ROWS_USED    = 4'd6,
        CFG_BRICK_COLUMNS_USED = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic               inf;
    } bound_t;

    function automatic logic [CNT_W-1:0] dim_clamp(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (v > CNT_W'(MAX_GRID_DIM)) begin
            return CNT_W'(MAX_GRID_DIM);
        end
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] count_clamp(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [NUM_W-1:0] ball_num(input logic [POS_W-1:0] v,
                                                  input logic [CNT_W-1:0] g);
        if (v[POS_W-1]) begin
            return '0;
        end
        return NUM_W'(v[POS_W-2:0]) * NUM_W'(g);
    endfunction

    // The upper edge is open when the window reaches the last cell, which also
    // collects every brick centre beyond the grid.
    function automatic bound_t cell_window(input logic [CELL_W-1:0] pos_cell,
                                           input logic [CNT_W-1:0] g,
                                           input logic [SPAN_W-1:0] span);
        bound_t             b;
        logic [CELL_W-1:0]  lo_cell;
        logic [BOUND_W-1:0] span2;
        span2   = {5'b0, span, 1'b0};
        lo_cell = (pos_cell == '0) ? '0 : pos_cell - CELL_W'(1);
        b.lo    = BOUND_W'(lo_cell) * span2;
        b.hi    = (BOUND_W'(pos_cell) + BOUND_W'(2)) * span2;
        b.inf   = (CNT_W'(pos_cell) + CNT_W'(2)) >= g;
        return b;
    endfunction

    function automatic logic in_window(input logic [ACC_W-1:0] acc, input bound_t b);
        return (acc >= ACC_W'(b.lo)) && (b.inf || (acc < ACC_W'(b.hi)));
    endfunction

endpackage

FILE: sv/uniform_grid_neighbour_query_core.sv
// Add, remove and clear-all are accepted back to back while the core is idle.
// A query holds the input until its last word has been issued: a five-step shared divider runs
// once per axis, then the window bounds, a column sweep of one column per cycle and a row sweep
// of one row per cycle while the output is not stalled. Results leave one word per matching row,
// m_last on the last one; with no matching row a single empty word carries m_last.
// Reset is synchronous, active low: control and config registers take defaults, the store empties.
module uniform_grid_neighbour_query_core import ugnq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [ROW_W-1:0]      s_brick_row,
    input  logic [COL_W-1:0]      s_brick_col,
    input  logic signed [POS_W-1:0] s_ball_x,
    input  logic signed [POS_W-1:0] s_ball_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROW_W-1:0]      m_hit_row,
    output logic [MAX_BRICK_COLS-1:0] m_hit_columns,
    output logic                  m_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [SPAN_W-1:0] sw_reg, sh_reg;
    logic [SIZE_W-1:0] bw_reg, bh_reg;
    logic [CNT_W-1:0]  gc_reg, gr_reg, nrows_reg, ncols_reg;

    logic [MAX_BRICK_COLS-1:0] present_reg [MAX_BRICK_ROWS];
    logic [MAX_BRICK_COLS-1:0] present_next [MAX_BRICK_ROWS];

    logic [POS_W-1:0]  ball_y_reg, ball_y_next;
    logic              axis_reg, axis_next;
    logic [2:0]        step_reg, step_next;
    logic [3:0]        quot_reg, quot_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [CELL_W-1:0] cell_x_reg, cell_x_next, cell_y_reg, cell_y_next;
    bound_t            bx_reg, bx_next, by_reg, by_next;
    logic [STEP_W-1:0] col_step_reg, col_step_next, row_step_reg, row_step_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [MAX_BRICK_COLS-1:0] colmask_reg, colmask_next;

    logic                      pend_valid_reg, pend_valid_next;
    logic [ROW_W-1:0]          pend_row_reg, pend_row_next;
    logic [MAX_BRICK_COLS-1:0] pend_mask_reg, pend_mask_next;

    logic                      m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]          m_row_reg, m_row_next;
    logic [MAX_BRICK_COLS-1:0] m_cols_reg, m_cols_next;
    logic                      m_last_reg, m_last_next;

    logic [SPAN_W-1:0] sw_eff, sh_eff;
    logic [SIZE_W-1:0] bw_eff, bh_eff;
    logic [CNT_W-1:0]  gc_eff, gr_eff, nrows_eff, ncols_eff;

    logic              s_accept, out_free;
    logic [CNT_W-1:0]  div_g;
    logic [SPAN_W-1:0] div_span;
    logic [DEN_W-1:0]  div_d;
    logic [2:0]        div_sh;
    logic [NUM_W-1:0]  div_dsh, div_rem;
    logic              div_ge;
    logic [4:0]        div_q;
    logic [CELL_W-1:0] div_gmax, div_cell;

    logic [MAX_BRICK_COLS-1:0] row_hits;
    logic                      row_match, row_stall;

    assign sw_eff    = (sw_reg == '0) ? SPAN_W'(1) : sw_reg;
    assign sh_eff    = (sh_reg == '0) ? SPAN_W'(1) : sh_reg;
    assign bw_eff    = (bw_reg == '0) ? SIZE_W'(1) : bw_reg;
    assign bh_eff    = (bh_reg == '0) ? SIZE_W'(1) : bh_reg;
    assign gc_eff    = dim_clamp(gc_reg);
    assign gr_eff    = dim_clamp(gr_reg);
    assign nrows_eff = count_clamp(nrows_reg, CNT_W'(MAX_BRICK_ROWS));
    assign ncols_eff = count_clamp(ncols_reg, CNT_W'(MAX_BRICK_COLS));

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_hit_row     = m_row_reg;
    assign m_hit_columns = m_cols_reg;
    assign m_last        = m_last_reg;

    // Shared restoring divider, one quotient bit per cycle.
    assign div_g    = axis_reg ? gr_eff : gc_eff;
    assign div_span = axis_reg ? sh_eff : sw_eff;
    assign div_d    = {div_span, 4'b0000};
    assign div_sh   = 3'(DIV_STEPS - 1) - step_reg;
    assign div_dsh  = NUM_W'(div_d) << div_sh;
    assign div_ge   = (rem_reg >= div_dsh);
    assign div_rem  = div_ge ? rem_reg - div_dsh : rem_reg;
    assign div_q    = {quot_reg, div_ge};
    assign div_gmax = CELL_W'(div_g - CNT_W'(1));
    assign div_cell = (div_q[4] || (div_q[3:0] > div_gmax)) ? div_gmax : div_q[3:0];

    assign row_hits  = present_reg[idx_reg[ROW_W-1:0]] & colmask_reg
                       & {MAX_BRICK_COLS{in_window(acc_reg, by_reg)}};
    assign row_match = (row_hits != '0);
    assign row_stall = row_match && pend_valid_reg && !out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (action_t'(s_action) == ACT_QUERY)) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if ((step_reg == 3'(DIV_STEPS - 1)) && axis_reg) begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND: begin
                state_next = ST_COLS;
            end
            ST_COLS: begin
                if (idx_reg == ncols_eff) begin
                    state_next = ST_ROWS;
                end
            end
            ST_ROWS: begin
                if (idx_reg == nrows_eff) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        present_next    = present_reg;
        ball_y_next     = ball_y_reg;
        axis_next       = axis_reg;
        step_next       = step_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        cell_x_next     = cell_x_reg;
        cell_y_next     = cell_y_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        col_step_next   = col_step_reg;
        row_step_next   = row_step_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        colmask_next    = colmask_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_mask_next  = pend_mask_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_row_next      = m_row_reg;
        m_cols_next     = m_cols_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (action_t'(s_action))
                        ACT_ADD: begin
                            if ((CNT_W'(s_brick_row) < nrows_eff)
                                && (CNT_W'(s_brick_col) < ncols_eff)) begin
                                present_next[s_brick_row][s_brick_col] = 1'b1;
                            end
                        end
                        ACT_REMOVE: begin
                            if ((CNT_W'(s_brick_row) < nrows_eff)
                                && (CNT_W'(s_brick_col) < ncols_eff)) begin
                                present_next[s_brick_row][s_brick_col] = 1'b0;
                            end
                        end
                        ACT_QUERY: begin
                            ball_y_next = s_ball_y;
                            axis_next   = 1'b0;
                            step_next   = '0;
                            quot_next   = '0;
                            rem_next    = ball_num(s_ball_x, gc_eff);
                        end
                        ACT_CLEAR: begin
                            for (int i = 0; i < MAX_BRICK_ROWS; i++) begin
                                present_next[i] = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                rem_next  = div_rem;
                quot_next = div_q[3:0];
                step_next = step_reg + 3'd1;
                if (step_reg == 3'(DIV_STEPS - 1)) begin
                    if (!axis_reg) begin
                        cell_x_next = div_cell;
                        axis_next   = 1'b1;
                        step_next   = '0;
                        quot_next   = '0;
                        rem_next    = ball_num(ball_y_reg, gr_eff);
                    end else begin
                        cell_y_next = div_cell;
                    end
                end
            end
            ST_BOUND: begin
                bx_next         = cell_window(cell_x_reg, gc_eff, sw_eff);
                by_next         = cell_window(cell_y_reg, gr_eff, sh_eff);
                col_step_next   = STEP_W'(bw_eff) * STEP_W'(gc_eff);
                row_step_next   = STEP_W'(bh_eff) * STEP_W'(gr_eff);
                acc_next        = ACC_W'(STEP_W'(bw_eff) * STEP_W'(gc_eff));
                idx_next        = '0;
                colmask_next    = '0;
                pend_valid_next = 1'b0;
            end
            ST_COLS: begin
                if (idx_reg != ncols_eff) begin
                    colmask_next[idx_reg[COL_W-1:0]] = in_window(acc_reg, bx_reg);
                    acc_next = acc_reg + ACC_W'({col_step_reg, 1'b0});
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    acc_next = ACC_W'(row_step_reg);
                    idx_next = '0;
                end
            end
            ST_ROWS: begin
                if ((idx_reg != nrows_eff) && !row_stall) begin
                    if (row_match) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_row_next   = pend_row_reg;
                            m_cols_next  = pend_mask_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_row_next   = idx_reg[ROW_W-1:0];
                        pend_mask_next  = row_hits;
                    end
                    acc_next = acc_reg + ACC_W'({row_step_reg, 1'b0});
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_row_next      = pend_valid_reg ? pend_row_reg : '0;
                    m_cols_next     = pend_valid_reg ? pend_mask_reg : '0;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            sw_reg         <= SPAN_W'(800);
            sh_reg         <= SPAN_W'(600);
            bw_reg         <= SIZE_W'(50);
            bh_reg         <= SIZE_W'(20);
            gc_reg         <= CNT_W'(4);
            gr_reg         <= CNT_W'(4);
            nrows_reg      <= CNT_W'(10);
            ncols_reg      <= CNT_W'(14);
            for (int i = 0; i < MAX_BRICK_ROWS; i++) begin
                present_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            present_reg    <= present_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_SCREEN_WIDTH:       sw_reg    <= cfg_data;
                    CFG_SCREEN_HEIGHT:      sh_reg    <= cfg_data;
                    CFG_BRICK_WIDTH:        bw_reg    <= cfg_data[SIZE_W-1:0];
                    CFG_BRICK_HEIGHT:       bh_reg    <= cfg_data[SIZE_W-1:0];
                    CFG_GRID_COLUMNS:       gc_reg    <= cfg_data[CNT_W-1:0];
                    CFG_GRID_ROWS:          gr_reg    <= cfg_data[CNT_W-1:0];
                    CFG_BRICK_ROWS_USED:    nrows_reg <= cfg_data[CNT_W-1:0];
                    CFG_BRICK_COLUMNS_USED: ncols_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ball_y_reg    <= ball_y_next;
        axis_reg      <= axis_next;
        step_reg      <= step_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        cell_x_reg    <= cell_x_next;
        cell_y_reg    <= cell_y_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        col_step_reg  <= col_step_next;
        row_step_reg  <= row_step_next;
        acc_reg       <= acc_next;
        idx_reg       <= idx_next;
        colmask_reg   <= colmask_next;
        pend_row_reg  <= pend_row_next;
        pend_mask_reg <= pend_mask_next;
        m_row_reg     <= m_row_next;
        m_cols_reg    <= m_cols_next;
        m_last_reg    <= m_last_next;
    end

endmodule
